@@ src/sols_pkg.sv @@
// shared types, codes and constants of the self-organizing linear search block
package sols_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned POL_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [POL_W-1:0] POLICY_PLAIN     = 2'd0;
  localparam logic [POL_W-1:0] POLICY_TRANSPOSE = 2'd1;
  localparam logic [POL_W-1:0] POLICY_TO_HEAD   = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SWAP_HIT,
    ST_SWAP_PART,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic issue;
    logic scan;
    logic wr_item;
    logic wr_hit;
    logic wr_partner;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic cnt_zero;
    logic more;
    logic hit;
    logic last_miss;
    logic move;
  } ctrl_status_t;

endpackage

@@ src/self_organizing_linear_search.sv @@
// top level of the self-organizing linear search table
//
// input channel: in_valid_i / in_stall_o with command_i, position_i, value_i.
// a write beat stores value_i at position_i (ignored when position_i >= DEPTH)
// and returns found 0, where = position. a search beat scans entries from 0 up
// to the saturated entries_in_use count and stops at the first equal entry.
// policy 1 swaps the hit with its predecessor, policy 2 swaps it with entry 0.
// output channel: out_valid_o / out_stall_i with found_o and where_o, one
// result beat per input beat, held in an output register.
// config channel: cfg_valid_i / cfg_ready_o (always ready), index 0 policy,
// index 1 entries_in_use; write only while idle.
// a write goes through exec to finish; a search scans until the first hit or
// the last entry (finish at once when the count is zero); the scan reads one
// entry per cycle through the registered table read port, and a swap writes
// the hit slot, then its partner, on the single write port. one beat is in
// flight and the next can be taken in the cycle after the result loads.
// a new beat is taken while the previous result still waits to be taken;
// when out_stall_i holds the output register full, a finished beat waits.
// reset clears control and config; table contents are undefined until written.
module self_organizing_linear_search #(
  parameter int unsigned DEPTH = sols_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sols_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sols_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [sols_pkg::POS_W-1:0]        position_i,
  input  logic signed [sols_pkg::KEY_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [sols_pkg::POS_W-1:0]        where_o
);
  import sols_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  sols_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .command_i  (command_i),
    .position_i (position_i),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .found_o    (found_o),
    .where_o    (where_o)
  );

  sols_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // busy right after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a beat without going busy");

  // a result appears exactly as the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result valid rose while still busy");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register loaded while stalled");

endmodule

@@ src/sols_datapath.sv @@
// table memory, scan counters, config registers and result register
module sols_datapath #(
  parameter int unsigned DEPTH = sols_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [sols_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sols_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              command_i,
  input  logic [sols_pkg::POS_W-1:0]        position_i,
  input  logic signed [sols_pkg::KEY_W-1:0] value_i,
  input  sols_pkg::ctrl_cmd_t               cmd_i,
  output sols_pkg::ctrl_status_t            status_o,
  output logic                              found_o,
  output logic [sols_pkg::POS_W-1:0]        where_o
);
  import sols_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = ($clog2(DEPTH + 1) > CNT_W) ? $clog2(DEPTH + 1) : CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [KEY_W-1:0] mem_q [DEPTH];

  logic [POL_W-1:0] policy_q;
  logic [CNT_W-1:0] entries_q;

  logic             cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [KEY_W-1:0] key_q;
  logic [CW-1:0]    addr_q;
  logic [AW-1:0]    ridx_q;
  logic             rvalid_q;
  logic [KEY_W-1:0] rdata_q;
  logic [KEY_W-1:0] prev_q;
  logic [KEY_W-1:0] head_q;
  logic             hit_q;
  logic [AW-1:0]    hit_idx_q;
  logic             found_q;
  logic [POS_W-1:0] where_q;

  logic [CW-1:0]    entries_ext;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    ridx_ext;
  logic             match;
  logic             pos_ok;
  logic [AW-1:0]    part_idx;
  logic [AW-1:0]    rep_idx;
  logic [CW-1:0]    rep_ext;
  logic [KEY_W-1:0] part_val;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POLICY_PLAIN;
      entries_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POLICY:  policy_q  <= cfg_data_i[POL_W-1:0];
        CFG_ENTRIES: entries_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign entries_ext = CW'(entries_q);
  assign cnt         = (entries_ext > DEPTH_C) ? DEPTH_C : entries_ext;
  assign pos_ext     = CW'(pos_q);
  assign pos_ok      = pos_ext < DEPTH_C;
  assign ridx_ext    = CW'(ridx_q);
  assign match       = rvalid_q && (rdata_q == key_q);

  assign part_idx = (policy_q == POLICY_TO_HEAD) ? '0 : hit_idx_q - AW'(1);
  assign part_val = (policy_q == POLICY_TO_HEAD) ? head_q : prev_q;

  always_comb begin
    rep_idx = hit_idx_q;
    if (policy_q == POLICY_TO_HEAD) begin
      rep_idx = '0;
    end else if (policy_q == POLICY_TRANSPOSE && hit_idx_q != '0) begin
      rep_idx = hit_idx_q - AW'(1);
    end
  end
  assign rep_ext = CW'(rep_idx);

  always_comb begin
    status_o.is_write  = (cmd_q == CMD_WRITE);
    status_o.cnt_zero  = (cnt == '0);
    status_o.more      = (addr_q < cnt);
    status_o.hit       = match;
    status_o.last_miss = rvalid_q && !match && (ridx_ext == cnt - CW'(1));
    status_o.move      = (policy_q == POLICY_TO_HEAD)
                      || (policy_q == POLICY_TRANSPOSE && ridx_q != '0);
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = key_q;
    if (cmd_i.wr_item) begin
      we    = pos_ok;
      waddr = pos_ext[AW-1:0];
      wdata = key_q;
    end else if (cmd_i.wr_hit) begin
      we    = 1'b1;
      waddr = hit_idx_q;
      wdata = part_val;
    end else if (cmd_i.wr_partner) begin
      we    = 1'b1;
      waddr = part_idx;
      wdata = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[addr_q[AW-1:0]];
      ridx_q  <= addr_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
      addr_q   <= '0;
    end else if (cmd_i.load) begin
      rvalid_q <= 1'b0;
      hit_q    <= 1'b0;
      addr_q   <= '0;
    end else begin
      rvalid_q <= cmd_i.issue;
      if (cmd_i.issue) begin
        addr_q <= addr_q + CW'(1);
      end
      if (cmd_i.scan && match) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      pos_q <= position_i;
      key_q <= value_i;
    end
    if (cmd_i.scan && match) begin
      hit_idx_q <= ridx_q;
    end
    if (cmd_i.scan && rvalid_q && !match) begin
      prev_q <= rdata_q;
    end
    if (cmd_i.scan && rvalid_q && ridx_q == '0) begin
      head_q <= rdata_q;
    end
    if (cmd_i.res_load) begin
      found_q <= (cmd_q == CMD_SEARCH) && hit_q;
      if (cmd_q == CMD_WRITE) begin
        where_q <= pos_q;
      end else if (hit_q) begin
        where_q <= rep_ext[POS_W-1:0];
      end else begin
        where_q <= '0;
      end
    end
  end

  assign found_o = found_q;
  assign where_o = where_q;

endmodule

@@ src/sols_ctrl.sv @@
// sequencing state machine and output valid of the search block
module sols_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  sols_pkg::ctrl_status_t status_i,
  output sols_pkg::ctrl_cmd_t    cmd_o
);
  import sols_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_write) begin
          cmd_o.wr_item = 1'b1;
          state_d       = ST_FINISH;
        end else if (status_i.cnt_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          state_d = status_i.move ? ST_SWAP_HIT : ST_FINISH;
        end else if (status_i.last_miss) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.issue = status_i.more;
        end
      end
      ST_SWAP_HIT: begin
        cmd_o.wr_hit = 1'b1;
        state_d      = ST_SWAP_PART;
      end
      ST_SWAP_PART: begin
        cmd_o.wr_partner = 1'b1;
        state_d          = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.res_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

endmodule

@@ test/tb_self_organizing_linear_search.sv @@
// testbench of the self-organizing linear search table, with a scoreboard class and a predictor
class sols_scoreboard;
  localparam int unsigned DEPTH = sols_pkg::DEFAULT_DEPTH;

  typedef struct packed {
    logic                      found;
    logic [sols_pkg::POS_W-1:0] where;
  } lookup_result_t;

  logic [sols_pkg::KEY_W-1:0] entry [DEPTH];
  logic [sols_pkg::POL_W-1:0] policy;
  logic [sols_pkg::CNT_W-1:0] entries_in_use;
  lookup_result_t             expected_lookups [$];
  int unsigned                mismatches;

  function new();
    policy         = sols_pkg::POLICY_PLAIN;
    entries_in_use = '0;
    mismatches     = 0;
  endfunction

  function void set_register(logic [sols_pkg::CFG_IDX_W-1:0] idx,
                             logic [sols_pkg::CFG_DAT_W-1:0] data);
    case (idx)
      sols_pkg::CFG_POLICY:  policy = data[sols_pkg::POL_W-1:0];
      sols_pkg::CFG_ENTRIES: entries_in_use = data[sols_pkg::CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned search_span();
    return (entries_in_use > DEPTH) ? DEPTH : int'(entries_in_use);
  endfunction

  function int unsigned pending();
    return expected_lookups.size();
  endfunction

  // applies one accepted beat to the shadow table and queues its result
  function void note_request(logic cmd, logic [sols_pkg::POS_W-1:0] pos,
                             logic [sols_pkg::KEY_W-1:0] val);
    lookup_result_t             res;
    logic [sols_pkg::KEY_W-1:0] held;
    bit                         hit;
    res = '0;
    hit = 1'b0;
    if (cmd == sols_pkg::CMD_WRITE) begin
      if (pos < DEPTH) entry[pos] = val;
      res.where = pos;
    end else begin
      for (int unsigned i = 0; i < search_span() && !hit; i++) begin
        if (entry[i] == val) begin
          hit       = 1'b1;
          res.found = 1'b1;
          res.where = sols_pkg::POS_W'(i);
          if (policy == sols_pkg::POLICY_TRANSPOSE && i > 0) begin
            held       = entry[i];
            entry[i]   = entry[i-1];
            entry[i-1] = held;
            res.where  = sols_pkg::POS_W'(i - 1);
          end else if (policy == sols_pkg::POLICY_TO_HEAD) begin
            held      = entry[i];
            entry[i]  = entry[0];
            entry[0]  = held;
            res.where = '0;
          end
        end
      end
    end
    expected_lookups.push_back(res);
  endfunction

  task report(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task check_response(logic found, logic [sols_pkg::POS_W-1:0] where);
    lookup_result_t exp;
    if (expected_lookups.size() == 0) begin
      report("result beat with nothing outstanding");
      return;
    end
    exp = expected_lookups.pop_front();
    if (found !== exp.found)
      report($sformatf("found %b, predicted %b", found, exp.found));
    if (where !== exp.where)
      report($sformatf("where %0d, predicted %0d", where, exp.where));
  endtask
endclass

module tb_self_organizing_linear_search;
  timeunit 1ns;
  timeprecision 1ps;
  import sols_pkg::*;

  localparam int unsigned DEPTH         = DEFAULT_DEPTH;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SEGMENTS      = 12;
  localparam int unsigned SEGMENT_BEATS = 73;
  localparam logic [POL_W-1:0] POLICY_SPARE = 2'd3;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]     cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic                     command_i   = CMD_WRITE;
  logic [POS_W-1:0]         position_i  = '0;
  logic signed [KEY_W-1:0]  value_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     found_o;
  logic [POS_W-1:0]         where_o;

  sols_scoreboard lookups;
  int unsigned    send_idle_pct  = 17;
  int unsigned    recv_stall_pct = 59;
  int unsigned    cycle_count    = 0;

  self_organizing_linear_search #(.DEPTH(DEPTH)) DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) lookups.check_response(found_o, where_o);
  end

  task automatic drive_item(logic cmd, logic [POS_W-1:0] pos, logic [KEY_W-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    lookups.note_request(cmd, pos, val);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lookups.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    lookups.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // block is idle here: every beat is answered before the config writes
  task automatic configure(logic [POL_W-1:0] pol, logic [CNT_W-1:0] cnt, bit junk_upper);
    logic [CFG_DAT_W-1:0] upper;
    wait_drain();
    repeat (4) @(negedge clk_i);
    upper = junk_upper ? $urandom : '0;
    write_register(CFG_POLICY, {upper[CFG_DAT_W-1:POL_W], pol});
    upper = junk_upper ? $urandom : '0;
    write_register(CFG_ENTRIES, {upper[CFG_DAT_W-1:CNT_W], cnt});
  endtask

  function automatic logic [KEY_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3, 4: return KEY_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned span;
    span = lookups.search_span();
    if (span > 0 && $urandom_range(0, 99) < 70)
      return lookups.entry[$urandom_range(0, span - 1)];
    if ($urandom_range(0, 99) < 30) return lookups.entry[$urandom_range(0, DEPTH - 1)];
    return pick_value();
  endfunction

  initial begin
    logic [KEY_W-1:0] fill [DEPTH];
    int unsigned seg_entries [SEGMENTS];
    fill = '{
      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
      32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0003, 32'h0000_0001,
      32'hdead_beef, 32'h0bad_cafe, 32'h0000_0002, 32'h0000_0003,
      32'h8000_0001, 32'h7fff_fffe, 32'hfedc_ba98, 32'h0246_8ace
    };
    seg_entries = '{16, 5, 31, 0, 2, 17, 16, 9, 1, 16, 12, 31};
    lookups = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // count zero: nothing is read yet
    drive_item(CMD_SEARCH, '0, 32'h8000_0000);
    for (int unsigned i = 0; i < DEPTH; i++) drive_item(CMD_WRITE, POS_W'(i), fill[i]);

    configure(POLICY_TRANSPOSE, 5'd16, 1'b0);
    drive_item(CMD_SEARCH, '0, fill[0]);
    drive_item(CMD_SEARCH, 4'hf, fill[15]);
    drive_item(CMD_SEARCH, '0, 32'h0000_0003);
    drive_item(CMD_SEARCH, '0, 32'h1234_5678);

    configure(POLICY_TO_HEAD, 5'd16, 1'b1);
    drive_item(CMD_SEARCH, '0, lookups.entry[9]);
    drive_item(CMD_SEARCH, '0, lookups.entry[15]);

    configure(POLICY_SPARE, 5'd31, 1'b1);
    drive_item(CMD_SEARCH, '0, lookups.entry[15]);

    configure(POLICY_PLAIN, 5'd1, 1'b0);
    drive_item(CMD_SEARCH, '0, lookups.entry[1]);

    for (int unsigned s = 0; s < SEGMENTS; s++) begin
      configure(POL_W'(s % 4), CNT_W'(seg_entries[s]), s[0]);
      case (s / 4)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 59;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int unsigned n = 0; n < SEGMENT_BEATS; n++) begin
        if ($urandom_range(0, 99) == 0) wait_drain();
        if ($urandom_range(0, 99) < 35)
          drive_item(CMD_WRITE, POS_W'($urandom_range(0, DEPTH - 1)), pick_value());
        else
          drive_item(CMD_SEARCH, POS_W'($urandom), pick_key());
      end
    end

    wait_drain();
    repeat (40) @(posedge clk_i);
    if (lookups.mismatches == 0 && lookups.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/sols_pkg.sv
src/sols_datapath.sv
src/sols_ctrl.sv
src/self_organizing_linear_search.sv
test/tb_self_organizing_linear_search.sv
